// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the sorted edge priority list.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under synchronous active-low reset
`define SEPL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sepl assertion failed");

// Next-cycle implication under synchronous active-low reset
`define SEPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sepl assertion failed");

`else

`define SEPL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SEPL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sepl_pkg.sv =====
// Package for the sorted edge priority list: request/status codes,
// transaction structs and the control bundle broadcast to the cells. No dependencies.
`default_nettype none

package sepl_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VERTEX_BITS_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int COUNT_OUT_W     = 7;

    // Request codes
    typedef enum logic [2:0] {
        REQ_INSERT       = 3'd0,
        REQ_REMOVE_EXACT = 3'd1,
        REQ_REMOVE_EDGE  = 3'd2,
        REQ_POP          = 3'd3,
        REQ_QUERY        = 3'd4
    } t_req_e;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status_e;

    // Input transaction
    typedef struct packed {
        logic [2:0]         req_type;
        logic [FIELD_W-1:0] node_a;
        logic [FIELD_W-1:0] node_b;
        logic [FIELD_W-1:0] priority_req;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [1:0]             status;
        logic [FIELD_W-1:0]     out_node_a;
        logic [FIELD_W-1:0]     out_node_b;
        logic [FIELD_W-1:0]     out_priority;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_out_item;

    // Request key and update strobes broadcast to every cell
    typedef struct packed {
        logic [FIELD_W-1:0] key_a;
        logic [FIELD_W-1:0] key_b;
        logic [FIELD_W-1:0] key_p;
        logic               need_prio;
        logic               pop_mode;
        logic               insert_en;
        logic               remove_en;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_edge_priority_list.sv =====
// Sorted edge priority list: a chain of CAPACITY cells kept in ascending priority.
// Insert: S_CMP, then S_DONE. Removals and query: S_CMP, a prefix scan of clog2(CAPACITY)
// steps in S_SCAN, S_READ, then S_DONE. One item in flight, output register decoupled.
// Reset (synchronous, active low) empties the list; slot contents are not cleared.
`default_nettype none
`include "assert_macros.svh"

module sorted_edge_priority_list #(
    parameter int CAPACITY    = sepl_pkg::CAPACITY_DEF,
    parameter int VERTEX_BITS = sepl_pkg::VERTEX_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire sepl_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output sepl_pkg::t_out_item      o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_SCAN = 5'b00100,
        S_READ = 5'b01000,
        S_DONE = 5'b10000
    } t_state_e;

    t_state_e                     r_state;
    t_state_e                     n_state;
    sepl_pkg::t_in_item           r_req;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_out_valid;
    sepl_pkg::t_out_item          r_out;
    sepl_pkg::t_out_item          n_out;
    logic [VERTEX_BITS-1:0]       r_sel_a;
    logic [VERTEX_BITS-1:0]       r_sel_b;
    logic [sepl_pkg::FIELD_W-1:0] r_sel_p;
    logic [VERTEX_BITS-1:0]       n_sel_a;
    logic [VERTEX_BITS-1:0]       n_sel_b;
    logic [sepl_pkg::FIELD_W-1:0] n_sel_p;

    logic                         w_accept;
    logic                         w_fire;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_is_insert;
    logic                         w_is_remove;
    logic                         w_insert_en;
    logic                         w_remove_en;
    logic                         w_found;
    logic                         w_scan_last;
    logic [CAPACITY-1:0]          w_hit;
    logic [CAPACITY-1:0]          w_lt;
    logic [CAPACITY-1:0]          w_first;
    logic [CAPACITY-1:0]          w_pre;
    logic [VERTEX_BITS-1:0]       w_a [CAPACITY];
    logic [VERTEX_BITS-1:0]       w_b [CAPACITY];
    logic [sepl_pkg::FIELD_W-1:0] w_p [CAPACITY];
    sepl_pkg::t_cell_ctrl         w_ctrl;

    // Handshakes
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_fire      = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Request decode
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_is_insert = (r_req.req_type == sepl_pkg::REQ_INSERT);
    assign w_is_remove = (r_req.req_type == sepl_pkg::REQ_REMOVE_EXACT) ||
                         (r_req.req_type == sepl_pkg::REQ_REMOVE_EDGE);
    assign w_insert_en = w_fire && w_is_insert && !w_full;
    assign w_remove_en = w_fire && w_is_remove && w_found;

    // Broadcast to the cells
    assign w_ctrl.key_a     = r_req.node_a;
    assign w_ctrl.key_b     = r_req.node_b;
    assign w_ctrl.key_p     = r_req.priority_req;
    assign w_ctrl.need_prio = (r_req.req_type == sepl_pkg::REQ_REMOVE_EXACT);
    assign w_ctrl.pop_mode  = (r_req.req_type == sepl_pkg::REQ_POP);
    assign w_ctrl.insert_en = w_insert_en;
    assign w_ctrl.remove_en = w_remove_en;

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VERTEX_BITS-1:0]       w_pa;
        logic [VERTEX_BITS-1:0]       w_pb;
        logic [sepl_pkg::FIELD_W-1:0] w_pp;
        logic                         w_plt;
        logic [VERTEX_BITS-1:0]       w_na;
        logic [VERTEX_BITS-1:0]       w_nb;
        logic [sepl_pkg::FIELD_W-1:0] w_np;

        if (g == 0) begin : g_head
            assign w_pa  = '0;
            assign w_pb  = '0;
            assign w_pp  = '0;
            assign w_plt = 1'b1;
        end else begin : g_body
            assign w_pa  = w_a[g-1];
            assign w_pb  = w_b[g-1];
            assign w_pp  = w_p[g-1];
            assign w_plt = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_na = '0;
            assign w_nb = '0;
            assign w_np = '0;
        end else begin : g_mid
            assign w_na = w_a[g+1];
            assign w_nb = w_b[g+1];
            assign w_np = w_p[g+1];
        end

        sepl_cell #(
            .VERTEX_BITS (VERTEX_BITS),
            .CNT_W       (CNT_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_count   (r_count),
            .i_prev_a  (w_pa),
            .i_prev_b  (w_pb),
            .i_prev_p  (w_pp),
            .i_prev_lt (w_plt),
            .i_next_a  (w_na),
            .i_next_b  (w_nb),
            .i_next_p  (w_np),
            .i_pre     (w_pre[g]),
            .o_a       (w_a[g]),
            .o_b       (w_b[g]),
            .o_p       (w_p[g]),
            .o_lt      (w_lt[g]),
            .o_hit     (w_hit[g])
        );
    end

    // First-match search; removal moves every slot from the match onward
    sepl_scan #(
        .N (CAPACITY)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_state == S_CMP),
        .i_step  (r_state == S_SCAN),
        .i_hit   (w_hit),
        .o_pre   (w_pre),
        .o_first (w_first),
        .o_found (w_found),
        .o_last  (w_scan_last)
    );

    // Read the matched slot: one-hot AND-OR
    always_comb begin
        n_sel_a = '0;
        n_sel_b = '0;
        n_sel_p = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                n_sel_a = n_sel_a | w_a[i];
                n_sel_b = n_sel_b | w_b[i];
                n_sel_p = n_sel_p | w_p[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_sel_a <= n_sel_a;
            r_sel_b <= n_sel_b;
            r_sel_p <= n_sel_p;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CMP;
            S_CMP: begin
                if (w_is_remove || w_ctrl.pop_mode ||
                    (r_req.req_type == sepl_pkg::REQ_QUERY)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: if (w_scan_last) n_state = S_READ;
            S_READ: n_state = S_DONE;
            S_DONE: if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
    end

    // Result and new fill count
    always_comb begin
        n_count                = r_count;
        n_out.status           = sepl_pkg::ST_OK;
        n_out.out_node_a       = '0;
        n_out.out_node_b       = '0;
        n_out.out_priority     = '0;
        unique case (sepl_pkg::t_req_e'(r_req.req_type))
            sepl_pkg::REQ_INSERT: begin
                if (w_full) begin
                    n_out.status = sepl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            sepl_pkg::REQ_REMOVE_EXACT, sepl_pkg::REQ_REMOVE_EDGE: begin
                if (w_empty) begin
                    n_out.status = sepl_pkg::ST_EMPTY;
                end else if (!w_found) begin
                    n_out.status = sepl_pkg::ST_NOT_FOUND;
                end else begin
                    n_out.out_priority = r_sel_p;
                    n_count            = r_count - CNT_W'(1);
                end
            end
            sepl_pkg::REQ_POP: begin
                if (w_empty) begin
                    n_out.status = sepl_pkg::ST_EMPTY;
                end else begin
                    n_out.out_node_a   = sepl_pkg::FIELD_W'(r_sel_a);
                    n_out.out_node_b   = sepl_pkg::FIELD_W'(r_sel_b);
                    n_out.out_priority = r_sel_p;
                    n_count            = r_count - CNT_W'(1);
                end
            end
            sepl_pkg::REQ_QUERY: begin
                if (!w_found) n_out.status = sepl_pkg::ST_NOT_FOUND;
            end
            default: begin
            end
        endcase
        n_out.entry_count = sepl_pkg::COUNT_OUT_W'(n_count);
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fire) begin
            r_count <= n_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    // Checks
    `SEPL_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SEPL_ASSERT_NEXT(a_accept_to_cmp, i_clk, i_rst_n, w_accept, r_state == S_CMP)
    `SEPL_ASSERT_IMPLY(a_found_nonempty, i_clk, i_rst_n, (r_state == S_READ) && w_found, !w_empty)
    `SEPL_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_insert_en, r_count == $past(r_count) + CNT_W'(1))

endmodule

`default_nettype wire

// ===== rtl/core/sepl_cell.sv =====
// One slot of the sorted list: holds an edge, compares it with the broadcast key
// and shifts to/from its neighbors. Depends on sepl_pkg.
`default_nettype none

module sepl_cell #(
    parameter int VERTEX_BITS = sepl_pkg::VERTEX_BITS_DEF,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
) (
    input  wire logic                            i_clk,
    input  wire sepl_pkg::t_cell_ctrl            i_ctrl,
    input  wire logic [CNT_W-1:0]                i_count,
    input  wire logic [VERTEX_BITS-1:0]          i_prev_a,
    input  wire logic [VERTEX_BITS-1:0]          i_prev_b,
    input  wire logic [sepl_pkg::FIELD_W-1:0]    i_prev_p,
    input  wire logic                            i_prev_lt,
    input  wire logic [VERTEX_BITS-1:0]          i_next_a,
    input  wire logic [VERTEX_BITS-1:0]          i_next_b,
    input  wire logic [sepl_pkg::FIELD_W-1:0]    i_next_p,
    input  wire logic                            i_pre,
    output logic      [VERTEX_BITS-1:0]          o_a,
    output logic      [VERTEX_BITS-1:0]          o_b,
    output logic      [sepl_pkg::FIELD_W-1:0]    o_p,
    output logic                                 o_lt,
    output logic                                 o_hit
);

    logic [VERTEX_BITS-1:0]       r_a;
    logic [VERTEX_BITS-1:0]       r_b;
    logic [sepl_pkg::FIELD_W-1:0] r_p;
    logic                         w_valid;
    logic                         w_last;
    logic                         w_edge_eq;

    // Occupancy follows from the fill count
    assign w_valid   = (i_count > CNT_W'(INDEX));
    assign w_last    = (i_count == CNT_W'(INDEX + 1));
    assign w_edge_eq = (r_a == i_ctrl.key_a[VERTEX_BITS-1:0]) &&
                       (r_b == i_ctrl.key_b[VERTEX_BITS-1:0]);

    // Local compare results
    assign o_lt  = w_valid && (r_p < i_ctrl.key_p);
    assign o_hit = w_valid && (i_ctrl.pop_mode ? w_last :
                   (w_edge_eq && (!i_ctrl.need_prio || (r_p == i_ctrl.key_p))));

    // Insert: first non-smaller slot takes the key, later slots take their left neighbor.
    // Remove: slots at and after the match take their right neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert_en && !o_lt) begin
            if (i_prev_lt) begin
                r_a <= i_ctrl.key_a[VERTEX_BITS-1:0];
                r_b <= i_ctrl.key_b[VERTEX_BITS-1:0];
                r_p <= i_ctrl.key_p;
            end else begin
                r_a <= i_prev_a;
                r_b <= i_prev_b;
                r_p <= i_prev_p;
            end
        end else if (i_ctrl.remove_en && i_pre) begin
            r_a <= i_next_a;
            r_b <= i_next_b;
            r_p <= i_next_p;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/core/sepl_scan.sv =====
// Iterative prefix-OR over the cell hit vector, one doubling step per cycle while i_step is high,
// giving the prefix mask, the first-hit one-hot and a found flag. Depends on nothing but its parameter.
`default_nettype none

module sepl_scan #(
    parameter int N = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire logic         i_step,
    input  wire logic [N-1:0] i_hit,
    output logic      [N-1:0] o_pre,
    output logic      [N-1:0] o_first,
    output logic              o_found,
    output logic              o_last
);

    localparam int LEVELS = $clog2(N);
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic [N-1:0]     r_pre;
    logic [LVL_W-1:0] r_lvl;

    // Level counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else if (i_load) begin
            r_lvl <= '0;
        end else if (i_step) begin
            r_lvl <= r_lvl + LVL_W'(1);
        end
    end

    // Doubling prefix OR
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pre <= i_hit;
        end else if (i_step) begin
            r_pre <= r_pre | (r_pre << (32'd1 << r_lvl));
        end
    end

    // Prefix mask: set at the first hit and every slot above it
    assign o_pre   = r_pre;
    assign o_last  = (r_lvl == LVL_W'(LEVELS - 1));
    assign o_found = r_pre[N-1];
    assign o_first = r_pre & ~(r_pre << 1);

endmodule

`default_nettype wire

// ===== verif/sorted_edge_priority_list_tb.sv =====
// Self-checking testbench for sorted_edge_priority_list: a directed table, then phased random
// list traffic; results checked against typed-in values or a behavioral copy of the sorted list.
// Depends on sepl_pkg and the sorted_edge_priority_list RTL; reads no files.
module sorted_edge_priority_list_tb;

    localparam int LIST_DEPTH    = sepl_pkg::CAPACITY_DEF;
    localparam int RANDOM_REQS   = 340;
    localparam int PHASE_LEN     = 60;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;

    // Request codes the block ignores
    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] HALF     = 32'h8000_0000;
    localparam logic [31:0] SCRAMBLE = 32'h9E37_79B9;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix_e;

    // One row of the directed table; reps > 1 walks node_a and the priority
    typedef struct packed {
        sepl_pkg::t_in_item  req;
        logic [6:0]          reps;
        logic                typed;
        sepl_pkg::t_out_item want;
    } t_step;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    sepl_pkg::t_in_item  in_item   = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    sepl_pkg::t_out_item out_item;

    // Behavioral copy of the list
    logic [31:0] edge_a    [LIST_DEPTH];
    logic [31:0] edge_b    [LIST_DEPTH];
    logic [31:0] edge_prio [LIST_DEPTH];
    int          edge_cnt = 0;

    sepl_pkg::t_out_item pending_results [$];
    t_step               script [$];

    int errors       = 0;
    int results_seen = 0;
    int reqs_sent    = 0;
    int full_seen    = 0;
    int empty_seen   = 0;
    int miss_seen    = 0;
    int peak_fill    = 0;
    bit send_no_wait  = 1'b0;
    bit sink_no_wait  = 1'b0;
    bit long_hold_req = 1'b0;

    sorted_edge_priority_list i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Index of the first endpoint match (and priority match if asked), else edge_cnt
    function automatic int find_edge(logic [31:0] a, logic [31:0] b, bit need_prio,
                                     logic [31:0] p);
        int i;
        i = 0;
        while (i < edge_cnt &&
               !(edge_a[i] == a && edge_b[i] == b && (!need_prio || edge_prio[i] == p)))
            i++;
        return i;
    endfunction

    // Apply one request to the list copy and return the result it must produce
    function automatic sepl_pkg::t_out_item list_apply(sepl_pkg::t_in_item rq);
        sepl_pkg::t_out_item res;
        int                  loc;
        int                  i;
        res        = '0;
        res.status = sepl_pkg::ST_OK;
        case (rq.req_type)
            sepl_pkg::REQ_INSERT: begin
                if (edge_cnt >= LIST_DEPTH) begin
                    res.status = sepl_pkg::ST_FULL;
                end else begin
                    // equal priority goes ahead of entries already held
                    loc = 0;
                    while (loc < edge_cnt && edge_prio[loc] < rq.priority_req) loc++;
                    for (i = edge_cnt; i > loc; i--) begin
                        edge_a[i]    = edge_a[i-1];
                        edge_b[i]    = edge_b[i-1];
                        edge_prio[i] = edge_prio[i-1];
                    end
                    edge_a[loc]    = rq.node_a;
                    edge_b[loc]    = rq.node_b;
                    edge_prio[loc] = rq.priority_req;
                    edge_cnt++;
                end
            end
            sepl_pkg::REQ_REMOVE_EXACT, sepl_pkg::REQ_REMOVE_EDGE: begin
                if (edge_cnt == 0) begin
                    res.status = sepl_pkg::ST_EMPTY;
                end else begin
                    loc = find_edge(rq.node_a, rq.node_b,
                                    rq.req_type == sepl_pkg::REQ_REMOVE_EXACT,
                                    rq.priority_req);
                    if (loc >= edge_cnt) begin
                        res.status = sepl_pkg::ST_NOT_FOUND;
                    end else begin
                        res.out_priority = edge_prio[loc];
                        for (i = loc; i + 1 < edge_cnt; i++) begin
                            edge_a[i]    = edge_a[i+1];
                            edge_b[i]    = edge_b[i+1];
                            edge_prio[i] = edge_prio[i+1];
                        end
                        edge_cnt--;
                    end
                end
            end
            sepl_pkg::REQ_POP: begin
                if (edge_cnt == 0) begin
                    res.status = sepl_pkg::ST_EMPTY;
                end else begin
                    res.out_node_a   = edge_a[edge_cnt-1];
                    res.out_node_b   = edge_b[edge_cnt-1];
                    res.out_priority = edge_prio[edge_cnt-1];
                    edge_cnt--;
                end
            end
            sepl_pkg::REQ_QUERY: begin
                if (find_edge(rq.node_a, rq.node_b, 1'b0, '0) >= edge_cnt)
                    res.status = sepl_pkg::ST_NOT_FOUND;
            end
            default: ;
        endcase
        res.entry_count = edge_cnt[sepl_pkg::COUNT_OUT_W-1:0];
        return res;
    endfunction

    // Directed rows: checked against the list copy, or against a typed-in result
    function automatic void add_row(logic [2:0] rt, logic [31:0] a, logic [31:0] b,
                                    logic [31:0] p, int reps);
        t_step s;
        s                  = '0;
        s.req.req_type     = rt;
        s.req.node_a       = a;
        s.req.node_b       = b;
        s.req.priority_req = p;
        s.reps             = reps[6:0];
        script.insert(script.size(), s);
    endfunction

    function automatic void add_typed(logic [2:0] rt, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] p, sepl_pkg::t_status_e st,
                                      logic [31:0] oa, logic [31:0] ob, logic [31:0] op,
                                      int cnt);
        t_step s;
        s                    = '0;
        s.req.req_type       = rt;
        s.req.node_a         = a;
        s.req.node_b         = b;
        s.req.priority_req   = p;
        s.reps               = 7'd1;
        s.typed              = 1'b1;
        s.want.status        = st;
        s.want.out_node_a    = oa;
        s.want.out_node_b    = ob;
        s.want.out_priority  = op;
        s.want.entry_count   = cnt[sepl_pkg::COUNT_OUT_W-1:0];
        script.insert(script.size(), s);
    endfunction

    // A small vertex pool makes duplicates and hits common
    function automatic logic [31:0] pick_vertex();
        if ($urandom_range(0, 9) < 6)
            return $urandom_range(0, 7);
        return $urandom;
    endfunction

    // Priorities: narrow range for ties, the extremes, and full range
    function automatic logic [31:0] pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 15);
            4:          return '0;
            5:          return ALL_ONES;
            6:          return HALF;
            default:    return $urandom;
        endcase
    endfunction

    function automatic sepl_pkg::t_in_item make_request(t_mix_e mix);
        sepl_pkg::t_in_item rq;
        int unsigned        roll;
        int unsigned        cut_ins, cut_exact, cut_edge, cut_pop, cut_query;
        int                 k;
        int                 bitpos;
        int                 hit_tenths;
        case (mix)
            MIX_FILL: begin
                cut_ins = 70; cut_exact = 77; cut_edge = 84; cut_pop = 90; cut_query = 97;
            end
            MIX_DRAIN: begin
                cut_ins = 10; cut_exact = 35; cut_edge = 60; cut_pop = 83; cut_query = 97;
            end
            default: begin
                cut_ins = 35; cut_exact = 50; cut_edge = 65; cut_pop = 78; cut_query = 97;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < cut_ins)
            rq.req_type = sepl_pkg::REQ_INSERT;
        else if (roll < cut_exact)
            rq.req_type = sepl_pkg::REQ_REMOVE_EXACT;
        else if (roll < cut_edge)
            rq.req_type = sepl_pkg::REQ_REMOVE_EDGE;
        else if (roll < cut_pop)
            rq.req_type = sepl_pkg::REQ_POP;
        else if (roll < cut_query)
            rq.req_type = sepl_pkg::REQ_QUERY;
        else
            rq.req_type = 3'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
        rq.node_a       = pick_vertex();
        rq.node_b       = pick_vertex();
        rq.priority_req = pick_priority();

        // Reuse a held edge so removals and queries hit; inserts sometimes duplicate one
        hit_tenths = (rq.req_type == sepl_pkg::REQ_INSERT) ? 2 : 7;
        if (edge_cnt > 0 && $urandom_range(0, 9) < hit_tenths) begin
            k         = $urandom_range(0, edge_cnt - 1);
            rq.node_a = edge_a[k];
            rq.node_b = edge_b[k];
            if (rq.req_type != sepl_pkg::REQ_INSERT)
                rq.priority_req = edge_prio[k];
            // near misses: endpoints swapped or one priority bit off
            case ($urandom_range(0, 7))
                0: begin
                    rq.node_a = edge_b[k];
                    rq.node_b = edge_a[k];
                end
                1: begin
                    bitpos                  = $urandom_range(0, 31);
                    rq.priority_req[bitpos] = ~rq.priority_req[bitpos];
                end
                default: ;
            endcase
        end
        return rq;
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic offer(sepl_pkg::t_in_item rq, bit typed, sepl_pkg::t_out_item want);
        int                  gap;
        sepl_pkg::t_out_item predicted;
        gap = send_no_wait ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= rq;
        do @(posedge clk); while (in_stall);
        predicted = list_apply(rq);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        reqs_sent++;
        if (edge_cnt > peak_fill)
            peak_fill = edge_cnt;
    endtask

    // Sender pause: nothing offered until every expected result is back
    task automatic await_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic check_result(sepl_pkg::t_out_item got);
        sepl_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            $error("result transaction with nothing expected: %h", got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        case (want.status)
            sepl_pkg::ST_FULL:      full_seen++;
            sepl_pkg::ST_EMPTY:     empty_seen++;
            sepl_pkg::ST_NOT_FOUND: miss_seen++;
            default: ;
        endcase
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.out_node_a !== want.out_node_a) begin
            $error("out_node_a: expected %h, got %h", want.out_node_a, got.out_node_a);
            errors++;
        end
        if (got.out_node_b !== want.out_node_b) begin
            $error("out_node_b: expected %h, got %h", want.out_node_b, got.out_node_b);
            errors++;
        end
        if (got.out_priority !== want.out_priority) begin
            $error("out_priority: expected %h, got %h", want.out_priority, got.out_priority);
            errors++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            errors++;
        end
    endtask

    // Result side: per-result stall drawn after each accept, counted while valid is up
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                check_result(out_item);
                stall_left = sink_no_wait ? 0 : $urandom_range(0, 3);
            end else if (out_stall && out_valid && stall_left > 0) begin
                stall_left--;
            end
            // long back-pressure so the block fills and stalls its input
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = 0;
                out_stall    <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            out_stall <= (stall_left > 0);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("sorted_edge_priority_list verification failed");
        $finish;
    end

    initial begin : stimulus
        sepl_pkg::t_in_item rq;
        t_mix_e             mix;
        int                 n;
        int                 k;
        int                 phase;
        int                 random_reqs;
        bit                 quiet;

        // Empty list: every removal reports empty, query misses
        add_typed(sepl_pkg::REQ_POP,          0, 0, 0, sepl_pkg::ST_EMPTY, 0, 0, 0, 0);
        add_typed(sepl_pkg::REQ_REMOVE_EXACT, 1, 2, 3, sepl_pkg::ST_EMPTY, 0, 0, 0, 0);
        add_typed(sepl_pkg::REQ_REMOVE_EDGE,  1, 2, 3, sepl_pkg::ST_EMPTY, 0, 0, 0, 0);
        add_typed(sepl_pkg::REQ_QUERY,        1, 2, 0, sepl_pkg::ST_NOT_FOUND, 0, 0, 0, 0);
        // Extremes of every field, plus a priority tie
        add_typed(sepl_pkg::REQ_INSERT, 1, 2, HALF, sepl_pkg::ST_OK, 0, 0, 0, 1);
        add_typed(sepl_pkg::REQ_INSERT, ALL_ONES, ALL_ONES, ALL_ONES,
                  sepl_pkg::ST_OK, 0, 0, 0, 2);
        add_typed(sepl_pkg::REQ_INSERT, 0, 0, 0, sepl_pkg::ST_OK, 0, 0, 0, 3);
        add_typed(sepl_pkg::REQ_INSERT, 5, 6, HALF, sepl_pkg::ST_OK, 0, 0, 0, 4);
        // Query is order sensitive
        add_typed(sepl_pkg::REQ_QUERY, 1, 2, 0, sepl_pkg::ST_OK,        0, 0, 0, 4);
        add_typed(sepl_pkg::REQ_QUERY, 2, 1, 0, sepl_pkg::ST_NOT_FOUND, 0, 0, 0, 4);
        // Exact remove needs the priority too
        add_typed(sepl_pkg::REQ_REMOVE_EXACT, 1, 2, HALF + 1,
                  sepl_pkg::ST_NOT_FOUND, 0, 0, 0, 4);
        add_typed(sepl_pkg::REQ_REMOVE_EXACT, 1, 2, HALF, sepl_pkg::ST_OK, 0, 0, HALF, 3);
        add_typed(sepl_pkg::REQ_REMOVE_EDGE,  5, 6, 0, sepl_pkg::ST_OK, 0, 0, HALF, 2);
        add_typed(sepl_pkg::REQ_REMOVE_EDGE,  9, 9, 0, sepl_pkg::ST_NOT_FOUND, 0, 0, 0, 2);
        // Unknown request codes are ignored
        add_typed(REQ_SPARE_A, 0, 0, 0, sepl_pkg::ST_OK, 0, 0, 0, 2);
        add_typed(REQ_SPARE_B, 7, 8, 9, sepl_pkg::ST_OK, 0, 0, 0, 2);
        add_typed(REQ_SPARE_C, ALL_ONES, ALL_ONES, ALL_ONES, sepl_pkg::ST_OK, 0, 0, 0, 2);
        add_typed(sepl_pkg::REQ_POP, 0, 0, 0, sepl_pkg::ST_OK,
                  ALL_ONES, ALL_ONES, ALL_ONES, 1);
        add_typed(sepl_pkg::REQ_POP, 0, 0, 0, sepl_pkg::ST_OK, 0, 0, 0, 0);
        // Tie order: the later insert sits ahead, so the first one pops first
        add_row(sepl_pkg::REQ_INSERT, 5, 6, 32'h4000_0000, 1);
        add_row(sepl_pkg::REQ_INSERT, 7, 8, 32'h4000_0000, 1);
        add_row(sepl_pkg::REQ_POP, 0, 0, 0, 1);
        add_row(sepl_pkg::REQ_POP, 0, 0, 0, 1);
        // Fill to capacity, then an insert is dropped
        add_row(sepl_pkg::REQ_INSERT, 100, 200, 32'h1234_5678, LIST_DEPTH);
        add_typed(sepl_pkg::REQ_INSERT, 1, 1, 1, sepl_pkg::ST_FULL, 0, 0, 0, LIST_DEPTH);
        add_row(sepl_pkg::REQ_REMOVE_EDGE, 110, 200, 0, 1);
        add_row(sepl_pkg::REQ_POP, 0, 0, 0, 1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < script.size(); n++) begin
            for (k = 0; k < script[n].reps; k++) begin
                rq              = script[n].req;
                rq.node_a       = rq.node_a + 32'(k);
                rq.priority_req = rq.priority_req + 32'(k) * SCRAMBLE;
                offer(rq, script[n].typed, script[n].want);
            end
        end
        await_results();

        // Random phases: fill-heavy, drain-heavy or even mixes of list traffic
        random_reqs = 0;
        phase       = 0;
        while (random_reqs < RANDOM_REQS) begin
            mix          = (phase == 0) ? MIX_FILL : t_mix_e'($urandom_range(0, 2));
            quiet        = ($urandom_range(0, 3) == 0);
            send_no_wait = quiet || (phase == 1);
            sink_no_wait = quiet;
            if (phase == 1)
                long_hold_req = 1'b1;
            repeat (PHASE_LEN) begin
                rq = make_request(mix);
                offer(rq, 1'b0, '0);
                if (rq.req_type <= sepl_pkg::REQ_QUERY)
                    random_reqs++;
            end
            await_results();
            phase++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d list requests in %0d random phases, %0d results checked.",
                 reqs_sent, phase, results_seen);
        $display("Peak fill %0d of %0d; %0d full drops, %0d empty removals, %0d misses.",
                 peak_fill, LIST_DEPTH, full_seen, empty_seen, miss_seen);
        if (errors == 0)
            $display("sorted_edge_priority_list verification clean");
        else
            $display("sorted_edge_priority_list verification failed");
        $finish;
    end

endmodule
